FILE: rtl/core/rcl_pkg.sv
`default_nettype none

package rcl_pkg;

   localparam int REGIONS_DEFAULT = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CoordW = 31;
   localparam int IdW = 16;
   localparam int SlotW = 6;

   // command field codes
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_LIFT = 1'b1
   } cmd_type;

   // result status codes
   typedef enum logic [2:0] {
      STAT_LIFTED   = 3'd0,
      STAT_NONE     = 3'd1,
      STAT_DISJOINT = 3'd2,
      STAT_PARTIAL  = 3'd3,
      STAT_LOADED   = 3'd4,
      STAT_OVERFLOW = 3'd5
   } status_type;

   // work kinds handed from the front to the back
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,   // load into a slot that exists
      OP_SKIP  = 2'd1,   // load aimed beyond the table
      OP_QUERY = 2'd2
   } op_type;

   // one queued job; lo/hi are region bounds for loads, query bounds for lifts
   typedef struct packed {
      op_type            op;
      logic [SlotW-1:0]  slot;
      logic [CoordW-1:0] lo;
      logic [CoordW-1:0] hi;
      logic [IdW-1:0]    dst_id;
      logic [CoordW-1:0] dst_start;
      logic              minus;
   } job_type;

   // one table entry
   typedef struct packed {
      logic              valid;
      logic              minus;
      logic [IdW-1:0]    dst_id;
      logic [CoordW-1:0] dst_start;
      logic [CoordW-1:0] src_end;
      logic [CoordW-1:0] src_start;
   } entry_type;

   typedef struct packed {
      status_type        status;
      logic [IdW-1:0]    out_dst_id;
      logic [CoordW-1:0] out_start;
      logic [CoordW-1:0] out_end;
      logic              out_minus;
      logic [SlotW-1:0]  hit_slot;
   } result_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SCAN,
      BK_EVAL,
      BK_ADD,
      BK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

FILE: rtl/core/rcl_if.sv
`default_nettype none

interface rcl_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [5:0]  slot;
   logic [30:0] region_start;
   logic [30:0] region_end;
   logic [15:0] region_dst_id;
   logic [30:0] region_dst_start;
   logic        region_minus;
   logic [30:0] item_start;
   logic [30:0] item_end;

   modport source (
      output valid, cmd, slot, region_start, region_end, region_dst_id,
             region_dst_start, region_minus, item_start, item_end,
      input  ready
   );
   modport sink (
      input  valid, cmd, slot, region_start, region_end, region_dst_id,
             region_dst_start, region_minus, item_start, item_end,
      output ready
   );
endinterface

interface rcl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] out_dst_id;
   logic [30:0] out_start;
   logic [30:0] out_end;
   logic        out_minus;
   logic [5:0]  hit_slot;

   modport source (
      output valid, status, out_dst_id, out_start, out_end, out_minus, hit_slot,
      input  ready
   );
   modport sink (
      input  valid, status, out_dst_id, out_start, out_end, out_minus, hit_slot,
      output ready
   );
endinterface

`default_nettype wire

FILE: rtl/core/rcl_front.sv
`default_nettype none

// Takes request beats, sorts them into job kinds, packs the fields.
module rcl_front #(
   parameter int REGIONS = rcl_pkg::REGIONS_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   rcl_req_if.sink             req,
   output rcl_pkg::job_type    push_job,
   output logic                push,
   input  wire logic           queue_full
);

   rcl_pkg::job_type hold_ff, hold_in;
   logic             hold_valid_ff, hold_valid_in;
   logic             accept;

   assign push      = hold_valid_ff && !queue_full;
   assign req.ready = !hold_valid_ff || !queue_full;
   assign accept    = req.valid && req.ready;
   assign push_job  = hold_ff;

   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff && !push;
      if (accept) begin
         hold_valid_in    = 1'b1;
         hold_in.slot     = req.slot;
         hold_in.dst_id   = req.region_dst_id;
         hold_in.dst_start = req.region_dst_start;
         hold_in.minus    = req.region_minus;
         if (req.cmd == rcl_pkg::CMD_LIFT) begin
            hold_in.op = rcl_pkg::OP_QUERY;
            hold_in.lo = req.item_start;
            hold_in.hi = req.item_end;
         end else begin
            hold_in.op = (32'(req.slot) < 32'(REGIONS)) ? rcl_pkg::OP_WRITE
                                                        : rcl_pkg::OP_SKIP;
            hold_in.lo = req.region_start;
            hold_in.hi = req.region_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/rcl_queue.sv
`default_nettype none

// Short job queue between front and back.
module rcl_queue #(
   parameter int QUEUE_DEPTH = rcl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rcl_pkg::job_type push_job,
   input  wire logic             push,
   output logic                  full,
   output rcl_pkg::job_type      pop_job,
   input  wire logic             pop,
   output logic                  empty
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

   rcl_pkg::job_type   slots_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;

   assign full    = (count_ff == FullCnt);
   assign empty   = (count_ff == '0);
   assign pop_job = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/core/rcl_back.sv
`default_nettype none

// Region table, scan sequencer, containment tests, lift arithmetic, result register.
module rcl_back #(
   parameter int REGIONS = rcl_pkg::REGIONS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rcl_pkg::job_type pop_job,
   input  wire logic             queue_empty,
   output logic                  pop,
   rcl_rsp_if.source             rsp
);

   localparam int AddrW = $clog2(REGIONS);
   localparam logic [AddrW-1:0] LastSlot = AddrW'(REGIONS - 1);
   localparam int CoordW = rcl_pkg::CoordW;

   rcl_pkg::back_state_type state_ff, state_in;

   rcl_pkg::entry_type  region_mem_ff [REGIONS];
   logic                mem_we;
   logic [AddrW-1:0]    mem_waddr;
   rcl_pkg::entry_type  mem_wdata;

   logic [AddrW-1:0]    clr_ff, clr_in;
   logic [AddrW-1:0]    issue_ff, issue_in;
   logic [AddrW-1:0]    rd_tag_ff;
   logic                rd_live_ff;
   rcl_pkg::entry_type  rd_data_ff;

   logic [CoordW-1:0]   qs_ff, qs_in, qe_ff, qe_in;
   rcl_pkg::entry_type  hit_ff, hit_in;
   logic [5:0]          hit_slot_ff, hit_slot_in;
   logic [CoordW-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   rcl_pkg::result_type res_ff, res_in;
   rcl_pkg::result_type out_ff, out_in;
   logic                out_valid_ff, out_valid_in;

   logic                out_free;
   logic                scan_hit, scan_miss;
   logic                disjoint, partial;
   logic [CoordW:0]     sum_lo, sum_hi;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign scan_hit  = rd_live_ff && rd_data_ff.valid && (qs_ff < rd_data_ff.src_end);
   assign scan_miss = rd_live_ff && (rd_tag_ff == LastSlot);
   assign disjoint  = (qe_ff <= hit_ff.src_start) || (qs_ff >= hit_ff.src_end);
   assign partial   = (qs_ff < hit_ff.src_start) || (qe_ff > hit_ff.src_end);
   assign sum_lo    = {1'b0, lo_ff} + {1'b0, hit_ff.dst_start};
   assign sum_hi    = {1'b0, hi_ff} + {1'b0, hit_ff.dst_start};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcl_pkg::BK_CLEAR: begin
            if (clr_ff == LastSlot) begin
               state_in = rcl_pkg::BK_IDLE;
            end
         end
         rcl_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               state_in = (pop_job.op == rcl_pkg::OP_QUERY) ? rcl_pkg::BK_SCAN
                                                            : rcl_pkg::BK_EMIT;
            end
         end
         rcl_pkg::BK_SCAN: begin
            if (scan_hit) begin
               state_in = rcl_pkg::BK_EVAL;
            end else if (scan_miss) begin
               state_in = rcl_pkg::BK_EMIT;
            end
         end
         rcl_pkg::BK_EVAL: begin
            state_in = (disjoint || partial) ? rcl_pkg::BK_EMIT : rcl_pkg::BK_ADD;
         end
         rcl_pkg::BK_ADD: begin
            state_in = rcl_pkg::BK_EMIT;
         end
         rcl_pkg::BK_EMIT: begin
            if (out_free) begin
               state_in = rcl_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = rcl_pkg::BK_IDLE;
         end
      endcase
   end

   // datapath controls
   always_comb begin
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;
      clr_in       = clr_ff;
      issue_in     = (issue_ff == LastSlot) ? issue_ff : issue_ff + 1'b1;
      qs_in        = qs_ff;
      qe_in        = qe_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      unique case (state_ff)
         rcl_pkg::BK_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         rcl_pkg::BK_IDLE: begin
            issue_in = '0;
            if (!queue_empty) begin
               pop = 1'b1;
               res_in = '0;
               res_in.status = rcl_pkg::STAT_LOADED;
               res_in.hit_slot = pop_job.slot;
               unique case (pop_job.op)
                  rcl_pkg::OP_WRITE: begin
                     mem_we              = 1'b1;
                     mem_waddr           = AddrW'(pop_job.slot);
                     mem_wdata.valid     = 1'b1;
                     mem_wdata.minus     = pop_job.minus;
                     mem_wdata.dst_id    = pop_job.dst_id;
                     mem_wdata.dst_start = pop_job.dst_start;
                     mem_wdata.src_end   = pop_job.hi;
                     mem_wdata.src_start = pop_job.lo;
                  end
                  rcl_pkg::OP_QUERY: begin
                     qs_in = pop_job.lo;
                     qe_in = pop_job.hi;
                  end
                  default: begin
                  end
               endcase
            end
         end
         rcl_pkg::BK_SCAN: begin
            if (scan_hit) begin
               hit_in      = rd_data_ff;
               hit_slot_in = 6'(rd_tag_ff);
            end else if (scan_miss) begin
               res_in        = '0;
               res_in.status = rcl_pkg::STAT_NONE;
            end
         end
         rcl_pkg::BK_EVAL: begin
            res_in          = '0;
            res_in.hit_slot = hit_slot_ff;
            if (disjoint) begin
               res_in.status = rcl_pkg::STAT_DISJOINT;
            end else if (partial) begin
               res_in.status = rcl_pkg::STAT_PARTIAL;
            end
            if (hit_ff.minus) begin
               lo_in = hit_ff.src_end - qe_ff;
               hi_in = hit_ff.src_end - qs_ff;
            end else begin
               lo_in = qs_ff - hit_ff.src_start;
               hi_in = qe_ff - hit_ff.src_start;
            end
         end
         rcl_pkg::BK_ADD: begin
            res_in            = '0;
            res_in.hit_slot   = hit_slot_ff;
            res_in.out_dst_id = hit_ff.dst_id;
            res_in.out_minus  = hit_ff.minus;
            if (sum_lo[CoordW] || sum_hi[CoordW]) begin
               res_in.status = rcl_pkg::STAT_OVERFLOW;
            end else begin
               res_in.status    = rcl_pkg::STAT_LIFTED;
               res_in.out_start = sum_lo[CoordW-1:0];
               res_in.out_end   = sum_hi[CoordW-1:0];
            end
         end
         rcl_pkg::BK_EMIT: begin
            if (out_free) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // region table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         region_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= region_mem_ff[issue_ff];
      rd_tag_ff  <= issue_ff;
   end

   always_ff @(posedge clock) begin
      qs_ff       <= qs_in;
      qe_ff       <= qe_in;
      hit_ff      <= hit_in;
      hit_slot_ff <= hit_slot_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
      if (reset) begin
         state_ff     <= rcl_pkg::BK_CLEAR;
         clr_ff       <= '0;
         issue_ff     <= '0;
         rd_live_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issue_ff     <= issue_in;
         rd_live_ff   <= (state_ff == rcl_pkg::BK_SCAN);
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.status     = out_ff.status;
   assign rsp.out_dst_id = out_ff.out_dst_id;
   assign rsp.out_start  = out_ff.out_start;
   assign rsp.out_end    = out_ff.out_end;
   assign rsp.out_minus  = out_ff.out_minus;
   assign rsp.hit_slot   = out_ff.hit_slot;

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == rcl_pkg::BK_IDLE))
      else $error("job taken outside idle");
   a_hit_is_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcl_pkg::BK_SCAN && scan_hit) |=> hit_ff.valid)
      else $error("scan stopped on an empty slot");
   a_emit_loads_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcl_pkg::BK_EMIT && out_free) |=> out_valid_ff)
      else $error("result lost on emit");
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcl_pkg::BK_SCAN) |-> !mem_we)
      else $error("table written during a scan");

endmodule

`default_nettype wire

FILE: rtl/core/region_coordinate_lift.sv
// Channel  | Dir | Beat contents
// ---------+-----+------------------------------------------------------------
// req_bus  | in  | cmd, slot, region_start/end/dst_id/dst_start/minus,
//          |     | item_start, item_end
// rsp_bus  | out | status, out_dst_id, out_start, out_end, out_minus, hit_slot
//
// A load beat passes the front register and the queue, is written if its slot
// exists and is emitted; a lift beat scans one slot per cycle through the single
// registered read port up to the first hit or the last slot, then takes a test,
// an add if contained, and an emit. After reset a clearing pass zeroes the table;
// request beats queue up in front and queue meanwhile. Reset is synchronous,
// active high. Beats are taken during a scan or rsp_bus stall until the queue fills.
`default_nettype none

module region_coordinate_lift #(
   parameter int REGIONS     = rcl_pkg::REGIONS_DEFAULT,
   parameter int QUEUE_DEPTH = rcl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   rcl_req_if.sink   req_bus,
   rcl_rsp_if.source rsp_bus
);

   rcl_pkg::job_type push_job;
   rcl_pkg::job_type pop_job;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;

   // front: accept and sort beats
   rcl_front #(
      .REGIONS (REGIONS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_job   (push_job),
      .push       (push),
      .queue_full (queue_full)
   );

   // decoupling queue
   rcl_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_job (push_job),
      .push     (push),
      .full     (queue_full),
      .pop_job  (pop_job),
      .pop      (pop),
      .empty    (queue_empty)
   );

   // back: table, scan, lift arithmetic, result register
   rcl_back #(
      .REGIONS (REGIONS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_job     (pop_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp         (rsp_bus)
   );

endmodule

`default_nettype wire

FILE: tb/region_coordinate_lift_tb.sv
module region_coordinate_lift_tb;
   import rcl_pkg::*;

   // Random beats after the directed opening
   localparam int ITEMS = 1700;
   localparam int SLOTS = REGIONS_DEFAULT;
   localparam longint TOP_COORD = 64'h7FFF_FFFF;
   // Receiver hold-off length.  It must outlast the job queue so that the front stalls.
   localparam int CHOKE_CYCLES = 400;

   // One request beat, in the same field order as the channel.
   typedef struct packed {
      cmd_type           cmd;
      logic [SlotW-1:0]  slot;
      logic [CoordW-1:0] region_start;
      logic [CoordW-1:0] region_end;
      logic [IdW-1:0]    region_dst_id;
      logic [CoordW-1:0] region_dst_start;
      logic              region_minus;
      logic [CoordW-1:0] item_start;
      logic [CoordW-1:0] item_end;
   } req_beat_type;

   // Our own copy of the region table
   typedef struct {
      bit                valid;
      logic [CoordW-1:0] lo;
      logic [CoordW-1:0] hi;
      logic [CoordW-1:0] base;
      logic [IdW-1:0]    id;
      logic              minus;
   } region_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rcl_req_if req_bus ();
   rcl_rsp_if rsp_bus ();

   region_coordinate_lift uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   region_entry_type region_tbl [SLOTS];
   req_beat_type     pending_beats [$];   // stimulus not yet offered
   result_type       due_outcomes [$];    // results predicted for accepted beats, oldest first
   req_beat_type     on_offer;
   result_type       want;

   // Shadow of the layout being planned.  It is used only to aim the queries.
   longint lay_lo [SLOTS];
   longint lay_hi [SLOTS];
   int     lay_n = 0;

   int  beats_queued = 0;
   int  beats_taken = 0;
   int  results_checked = 0;
   int  mismatches = 0;
   int  status_seen [8];
   int  send_gap = 0;
   int  send_calm = 0;
   int  recv_gap = 0;
   int  recv_calm = 0;
   logic choke = 1'b0;

   // ------------------------------------------------------------------
   // Predictor: apply one accepted beat to the shadow table and work out
   // the result beat the block owes for it.
   // ------------------------------------------------------------------
   function automatic result_type lift_beat(req_beat_type b);
      result_type        r;
      region_entry_type  e;
      int                k;
      int                hit;
      logic [CoordW+1:0] os;
      logic [CoordW+1:0] oe;
      r = '0;
      if (b.cmd == CMD_LOAD) begin
         // Loads aimed past the table write nothing but still report the slot.
         if (int'(b.slot) < SLOTS) begin
            region_tbl[b.slot] = '{1'b1, b.region_start, b.region_end, b.region_dst_start,
                                   b.region_dst_id, b.region_minus};
         end
         r.status = STAT_LOADED;
         r.hit_slot = b.slot;
         return r;
      end
      // The first valid slot whose end lies above the query start wins.  The scan stops there.
      hit = -1;
      for (k = 0; k < SLOTS; k++) begin
         if (hit < 0 && region_tbl[k].valid && b.item_start < region_tbl[k].hi) hit = k;
      end
      if (hit < 0) begin
         r.status = STAT_NONE;
         return r;
      end
      e = region_tbl[hit];
      r.hit_slot = hit[SlotW-1:0];
      if (b.item_end <= e.lo || b.item_start >= e.hi) begin
         r.status = STAT_DISJOINT;
      end else if (b.item_start < e.lo || b.item_end > e.hi) begin
         r.status = STAT_PARTIAL;
      end else begin
         // Containment holds, so no difference below can go negative.  Two spare bits
         // hold the carry that shows overflow.
         if (!e.minus) begin
            os = {2'b00, b.item_start} - {2'b00, e.lo} + {2'b00, e.base};
            oe = {2'b00, b.item_end} - {2'b00, e.lo} + {2'b00, e.base};
         end else begin
            // Reverse strand: mirror about the region end.
            os = {2'b00, e.hi} - {2'b00, b.item_end} + {2'b00, e.base};
            oe = {2'b00, e.hi} - {2'b00, b.item_start} + {2'b00, e.base};
         end
         r.out_dst_id = e.id;
         r.out_minus = e.minus;
         if (os[CoordW+1:CoordW] != 2'b00 || oe[CoordW+1:CoordW] != 2'b00) begin
            r.status = STAT_OVERFLOW;
         end else begin
            r.status = STAT_LIFTED;
            r.out_start = os[CoordW-1:0];
            r.out_end = oe[CoordW-1:0];
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
         mismatches++;
      end
   endtask

   // Idle length: mostly none or short, now and then a long one,
   // and occasionally a stretch of back-to-back beats.
   function automatic int pick_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r == 0) begin
         calm_left = $urandom_range(20, 120);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 90);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic longint rand_between(longint lo, longint hi);
      longint unsigned r;
      if (hi <= lo) return lo;
      r = {$urandom, $urandom};
      return lo + longint'(r % longint'(hi - lo + 1));
   endfunction

   function automatic longint rnd31();
      return longint'($urandom) & TOP_COORD;
   endfunction

   function automatic logic [CoordW-1:0] clip31(longint v);
      longint c;
      c = (v < 0) ? 0 : (v > TOP_COORD) ? TOP_COORD : v;
      return c[CoordW-1:0];
   endfunction

   // Fields that the command does not use still carry random values.  This
   // toggles every input bit and checks that the block ignores them.
   function automatic req_beat_type random_beat();
      req_beat_type b;
      bit [31:0]    w;
      w = $urandom;
      b.cmd = CMD_LOAD;
      b.slot = w[SlotW-1:0];
      b.region_minus = w[8];
      b.region_dst_id = w[31:16];
      b.region_start = clip31(rnd31());
      b.region_end = clip31(rnd31());
      b.region_dst_start = clip31(rnd31());
      b.item_start = clip31(rnd31());
      b.item_end = clip31(rnd31());
      return b;
   endfunction

   task automatic send_load(int slot, longint lo, longint hi, int id, longint base, bit minus);
      req_beat_type b;
      b = random_beat();
      b.cmd = CMD_LOAD;
      b.slot = slot[SlotW-1:0];
      b.region_start = clip31(lo);
      b.region_end = clip31(hi);
      b.region_dst_id = id[IdW-1:0];
      b.region_dst_start = clip31(base);
      b.region_minus = minus;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   task automatic send_query(longint qs, longint qe);
      req_beat_type b;
      b = random_beat();
      b.cmd = CMD_LIFT;
      b.item_start = clip31(qs);
      b.item_end = clip31(qe);
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   // Load slots 0..n-1 with regions in ascending start order.  Gaps may be zero.
   // A few regions are empty or inverted.  Wide layouts sit just under the top
   // coordinate, and the last of them sometimes ends on it.
   task automatic plan_layout(int n, bit wide);
      longint span;
      longint cur;
      longint lo;
      longint hi;
      longint base;
      int     k;
      int     r;
      span = wide ? 100000 : 200;
      cur = wide ? TOP_COORD - longint'(n) * 2 * span - rand_between(0, span)
                 : rand_between(0, 1000);
      for (k = 0; k < n; k++) begin
         lo = cur + rand_between(0, span / 4);
         hi = lo + rand_between(1, span);
         r = $urandom_range(0, 19);
         if (r == 0) hi = lo;
         else if (r == 1 && lo > 10) hi = lo - rand_between(1, 10);
         if (wide && k == n - 1 && $urandom_range(0, 1)) hi = TOP_COORD;
         if (hi > TOP_COORD) hi = TOP_COORD;
         cur = (hi > lo) ? hi : lo;
         lay_lo[k] = lo;
         lay_hi[k] = hi;
         r = $urandom_range(0, 9);
         // Destination starts near the top provoke overflow.
         base = (r < 5) ? rand_between(0, 1 << 20) :
                (r < 8) ? rnd31() : TOP_COORD - rand_between(0, span);
         send_load(k, lo, hi, $urandom_range(0, 16'hFFFF), base, $urandom_range(0, 1));
      end
      lay_n = n;
   endtask

   // A query aimed at one region of the current layout: most often contained,
   // the rest partial, disjoint, past the region end, inverted or pure noise.
   task automatic plan_query();
      longint lo;
      longint hi;
      longint qs;
      longint qe;
      int     r;
      r = $urandom_range(0, lay_n - 1);
      lo = lay_lo[r];
      hi = lay_hi[r];
      r = $urandom_range(0, 99);
      if (r < 45 && hi > lo) begin
         qs = ($urandom_range(0, 7) == 0) ? lo : rand_between(lo, hi - 1);
         qe = ($urandom_range(0, 7) == 0) ? hi : rand_between(qs + 1, hi);
      end else if (r < 52 && hi > lo) begin
         qs = rand_between(lo, hi - 1);
         qe = qs - rand_between(0, qs - lo);
      end else if (r < 67) begin
         if ($urandom_range(0, 1)) begin
            qs = lo - rand_between(1, 64);
            qe = rand_between(lo + 1, hi);
         end else begin
            qs = rand_between(lo, hi - 1);
            qe = hi + rand_between(1, 64);
         end
      end else if (r < 77) begin
         qe = lo - rand_between(0, 40);
         qs = qe - rand_between(1, 40);
      end else if (r < 82) begin
         qs = rand_between(hi, TOP_COORD);
         qe = rand_between(qs, TOP_COORD);
      end else begin
         qs = rnd31();
         qe = rnd31();
      end
      send_query(qs, qe);
   endtask

   // Hold off the sender until every outstanding result beat has come back.
   task automatic settle();
      while (beats_taken != beats_queued || due_outcomes.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: offers queued beats.  It never drops valid while a beat waits
   // for ready.  The result of each beat is predicted at the edge that
   // accepts it, so the predictor sees beats in the block's own order.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            due_outcomes.push_back(lift_beat(on_offer));
            beats_taken++;
            send_gap = pick_gap(send_calm);
         end
         if (req_bus.valid && !req_bus.ready) begin
            // beat still on offer: leave it alone
         end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            on_offer = pending_beats.pop_front();
            req_bus.cmd <= on_offer.cmd;
            req_bus.slot <= on_offer.slot;
            req_bus.region_start <= on_offer.region_start;
            req_bus.region_end <= on_offer.region_end;
            req_bus.region_dst_id <= on_offer.region_dst_id;
            req_bus.region_dst_start <= on_offer.region_dst_start;
            req_bus.region_minus <= on_offer.region_minus;
            req_bus.item_start <= on_offer.item_start;
            req_bus.item_end <= on_offer.item_end;
            req_bus.valid <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: takes result beats with random back-pressure and compares
   // each one field by field with the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            status_seen[rsp_bus.status]++;
            if (due_outcomes.size() == 0) begin
               $error("result beat with nothing outstanding: status %0d, slot %0d",
                      rsp_bus.status, rsp_bus.hit_slot);
               mismatches++;
            end else begin
               want = due_outcomes.pop_front();
               results_checked++;
               check_field("status", 64'(want.status), 64'(rsp_bus.status));
               check_field("out_dst_id", 64'(want.out_dst_id), 64'(rsp_bus.out_dst_id));
               check_field("out_start", 64'(want.out_start), 64'(rsp_bus.out_start));
               check_field("out_end", 64'(want.out_end), 64'(rsp_bus.out_end));
               check_field("out_minus", 64'(want.out_minus), 64'(rsp_bus.out_minus));
               check_field("hit_slot", 64'(want.hit_slot), 64'(rsp_bus.hit_slot));
            end
            recv_gap = pick_gap(recv_calm);
         end
         if (choke) begin
            rsp_bus.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-offs, counted here.  The sender keeps offering
   // beats, so the job queue fills and the block has to stall its input.
   initial begin
      for (int n = 1; n <= 2; n++) begin
         wait (beats_taken >= n * 600 - 300);
         @(posedge clock);
         choke <= 1'b1;
         repeat (CHOKE_CYCLES) @(posedge clock);
         choke <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int  first_random;
      int  n;
      int  r;
      bit  wide;
      bit  drained_midway;
      drained_midway = 1'b0;
      foreach (region_tbl[k]) region_tbl[k].valid = 1'b0;
      foreach (status_seen[k]) status_seen[k] = 0;
      req_bus.valid = 1'b0;
      req_bus.cmd = 1'b0;
      req_bus.slot = '0;
      req_bus.region_start = '0;
      req_bus.region_end = '0;
      req_bus.region_dst_id = '0;
      req_bus.region_dst_start = '0;
      req_bus.region_minus = 1'b0;
      req_bus.item_start = '0;
      req_bus.item_end = '0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part.  The first query runs on an empty table.  The table then
      // gets adjacent regions, an empty region, an inverted region, a region whose
      // destination sits near the top, one that ends on the top coordinate, and
      // the last slot.
      send_query(0, 100);
      send_load(0, 0, 200, 16'hFFFF, 1000, 1'b0);
      send_load(1, 200, 300, 1, 5000, 1'b1);
      send_load(2, 400, 400, 2, 7, 1'b0);
      send_load(3, 500, 450, 3, 9, 1'b1);
      send_load(4, 600, 700, 4, TOP_COORD - 47, 1'b0);
      send_load(5, 2147483000, TOP_COORD, 5, 0, 1'b1);
      send_load(SLOTS - 1, TOP_COORD - 1, TOP_COORD, 0, TOP_COORD, 1'b1);
      send_query(0, 200);                   // whole region, forward
      send_query(50, 60);
      send_query(150, 250);                 // runs past the region end
      send_query(350, 420);                 // starts before the empty region
      send_query(250, 250);                 // empty query on a reverse region
      send_query(290, 210);                 // inverted query, still contained
      send_query(300, 350);                 // lands in a gap
      send_query(440, 600);                 // meets the inverted region
      send_query(600, 601);                 // lifts just under the top
      send_query(610, 690);                 // forward overflow
      send_query(2147483000, TOP_COORD);    // reverse, extreme coordinates
      send_query(TOP_COORD, TOP_COORD);     // beyond every region end
      send_query(TOP_COORD - 1, 0);         // inverted, ends before the region
      send_load(4, 600, 700, 16'h8000, TOP_COORD, 1'b1);
      send_query(650, 660);                 // reverse overflow
      settle();

      // Random part: layouts of random size and scale, each followed by
      // queries aimed at its regions, with the odd stray load mixed in.
      first_random = beats_queued;
      while (beats_queued - first_random < ITEMS) begin
         r = $urandom_range(0, 9);
         n = (r < 4) ? $urandom_range(1, 8) :
             (r < 8) ? $urandom_range(9, 32) : $urandom_range(33, SLOTS);
         wide = ($urandom_range(0, 3) == 0);
         plan_layout(n, wide);
         repeat ($urandom_range(8, 40)) begin
            if ($urandom_range(0, 14) == 0) begin
               send_load($urandom_range(0, SLOTS - 1), rnd31(), rnd31(),
                         $urandom_range(0, 16'hFFFF), rnd31(), $urandom_range(0, 1));
            end else begin
               plan_query();
            end
         end
         // Halfway through, the sender waits until the block has gone quiet.
         if (!drained_midway && beats_queued - first_random >= ITEMS / 2) begin
            settle();
            drained_midway = 1'b1;
         end
      end
      settle();
      // Idle tail to catch any stray result beat
      repeat (SLOTS + 10) @(posedge clock);

      $display("Covered %0d beats and checked %0d results: lifted %0d, no region %0d,",
               beats_taken, results_checked, status_seen[STAT_LIFTED], status_seen[STAT_NONE]);
      $display("disjoint %0d, partial %0d, overflow %0d, loaded %0d",
               status_seen[STAT_DISJOINT], status_seen[STAT_PARTIAL],
               status_seen[STAT_OVERFLOW], status_seen[STAT_LOADED]);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #7000000;
      $error("timed out: %0d of %0d beats taken, %0d results outstanding",
             beats_taken, beats_queued, due_outcomes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
